FILE: sv/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request header parser package
// Parse state codes, line kinds and character constants.
// ----------------------------------------------------------------------------
package hrhp_pkg;

   localparam logic [3:0] S_START     = 4'd0;
   localparam logic [3:0] S_METHOD    = 4'd1;
   localparam logic [3:0] S_URI_BF    = 4'd2;
   localparam logic [3:0] S_URI_IN    = 4'd3;
   localparam logic [3:0] S_VER_BF    = 4'd4;
   localparam logic [3:0] S_VER_IN    = 4'd5;
   localparam logic [3:0] S_VER_END   = 4'd6;
   localparam logic [3:0] S_HOST_BF   = 4'd7;
   localparam logic [3:0] S_HOST_IN   = 4'd8;
   localparam logic [3:0] S_LINE_BF   = 4'd9;
   localparam logic [3:0] S_KEY_IN    = 4'd10;
   localparam logic [3:0] S_VALUE_BF  = 4'd11;
   localparam logic [3:0] S_VALUE_IN  = 4'd12;
   localparam logic [3:0] S_FIELD_END = 4'd13;

   localparam logic [3:0] KIND_IGNORE = 4'd0;
   localparam logic [3:0] KIND_HOST   = 4'd1;
   localparam logic [3:0] KIND_CONN   = 4'd8;
   localparam logic [3:0] KIND_RANGE  = 4'd9;

   localparam logic [1:0] ST_CONTINUE = 2'd0;
   localparam logic [1:0] ST_FINISHED = 2'd1;
   localparam logic [1:0] ST_INVALID  = 2'd2;

   localparam logic [7:0] CH_CR = 8'd13;
   localparam logic [7:0] CH_LF = 8'd10;

   localparam logic [31:0] HOST_TXT = "host";

   typedef logic [7:0] char_type;

   // Character of a method name at a position, zero past its end.
   function automatic char_type meth_char(input logic [1:0] m, input logic [4:0] p);
      logic [31:0] t;
      case (m)
         2'd0:    t = 32'("GET");
         2'd1:    t = 32'("PUT");
         2'd2:    t = "POST";
         default: t = "HEAD";
      endcase
      if (m < 2'd2) begin
         t = t << 8;
      end
      meth_char = (p < 5'd4) ? t[31 - 8*p[1:0] -: 8] : 8'd0;
   endfunction

   function automatic logic [4:0] meth_len(input logic [1:0] m);
      meth_len = (m < 2'd2) ? 5'd3 : 5'd4;
   endfunction

   function automatic char_type ver_char(input logic [1:0] v, input logic [4:0] p);
      logic [63:0] t;
      case (v)
         2'd0:    t = "HTTP/0.9";
         2'd1:    t = "HTTP/1.0";
         default: t = "HTTP/1.1";
      endcase
      ver_char = (p < 5'd8) ? t[63 - 8*p[2:0] -: 8] : 8'd0;
   endfunction

   function automatic char_type hdr_char(input logic [2:0] k, input logic [4:0] p);
      logic [119:0] t;
      logic [4:0]   n;
      case (k)
         3'd0:    begin t = 120'("connection");      n = 5'd10; end
         3'd1:    begin t = 120'("referer");         n = 5'd7;  end
         3'd2:    begin t = 120'("user-agent");      n = 5'd10; end
         3'd3:    begin t = 120'("accept");          n = 5'd6;  end
         3'd4:    begin t = 120'("accept-encoding"); n = 5'd15; end
         3'd5:    begin t = 120'("accept-language"); n = 5'd15; end
         3'd6:    begin t = 120'("range");           n = 5'd5;  end
         default: begin t = 120'("cookie");          n = 5'd6;  end
      endcase
      if (p < n) begin
         hdr_char = t[8*(n - p) - 1 -: 8];
      end else begin
         hdr_char = 8'd0;
      end
   endfunction

   function automatic logic [4:0] hdr_len(input logic [2:0] k);
      case (k)
         3'd0:    hdr_len = 5'd10;
         3'd1:    hdr_len = 5'd7;
         3'd2:    hdr_len = 5'd10;
         3'd3:    hdr_len = 5'd6;
         3'd4:    hdr_len = 5'd15;
         3'd5:    hdr_len = 5'd15;
         3'd6:    hdr_len = 5'd5;
         default: hdr_len = 5'd6;
      endcase
   endfunction

   // Referer to accept-language take field ids two to six, one above their
   // table position.
   function automatic logic [3:0] hdr_kind(input logic [2:0] k);
      case (k)
         3'd0:    hdr_kind = KIND_CONN;
         3'd6:    hdr_kind = KIND_RANGE;
         3'd7:    hdr_kind = 4'd7;
         default: hdr_kind = {1'b0, k} + 4'd1;
      endcase
   endfunction

   function automatic char_type close_char(input logic [4:0] p);
      logic [39:0] t;
      t = "close";
      close_char = (p < 5'd5) ? t[39 - 8*p -: 8] : 8'd0;
   endfunction

   function automatic char_type to_lower(input char_type c);
      to_lower = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

endpackage

FILE: sv/http_request_header_parser.sv
// ----------------------------------------------------------------------------
// HTTP request header parser
// Byte-wide request line and header parser with field capture.
// ----------------------------------------------------------------------------
// The block takes one request byte per transfer and returns one result per
// byte; at full rate a byte is accepted every clock cycle, set by the single
// pass of the per-byte compare and counter logic between the request
// register and the result register. The result appears in the cycle after
// its byte is accepted. A byte is accepted while the result register is
// empty or its result is taken in the same cycle, so a waiting result
// stalls the input. Captured fields are reported as store writes on the
// result; capacity is the smaller of the value written on csr_data and
// STORE_DEPTH. Status is sticky once finished or invalid until a restart.
module http_request_header_parser #(
   parameter int STORE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [10:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_store_write,
   output logic [9:0]  rsp_store_addr,
   output logic [7:0]  rsp_store_data,
   output logic        rsp_field_done,
   output logic [2:0]  rsp_field_id,
   output logic [9:0]  rsp_field_offset,
   output logic [10:0] rsp_field_length,
   output logic [1:0]  rsp_method,
   output logic [1:0]  rsp_version,
   output logic        rsp_keep_alive
);

   localparam int IW = $clog2(STORE_DEPTH + 1);
   localparam int CW = (IW > 11) ? IW : 11;
   localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

   logic [10:0]   cap_ff;
   logic [3:0]    st_ff, st_in;
   logic [CW-1:0] idx_ff, idx_in, fs_ff, fs_in;
   logic [4:0]    tl_ff, tl_in;
   logic [3:0]    mm_ff, mm_in, vm_ff, vm_in, lk_ff, lk_in;
   logic [7:0]    km_ff, km_in;
   logic          cm_ff, cm_in, bc_ff, bc_in, ka_ff, ka_in;
   logic [1:0]    mr_ff, mr_in, vr_ff, vr_in, fin_ff, fin_in;

   // A result leaves the output register when taken, so a new byte may
   // enter in the same cycle.
   assign req_ready = !rsp_valid || rsp_ready;
   logic take;
   assign take = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 11'd1024;
      end else if (csr_write) begin
         cap_ff <= csr_data;
      end
   end

   logic [CW-1:0] cap;
   assign cap = (CW'(cap_ff) < DEPTH_C) ? CW'(cap_ff) : DEPTH_C;

   logic          o_wr, o_fd;
   logic [9:0]    o_addr, o_off;
   logic [7:0]    o_data;
   logic [2:0]    o_id;
   logic [10:0]   o_len;

   always_comb begin
      logic [7:0]  b, lb;
      logic [1:0]  verdict;
      logic        keych, isval, got;
      logic [3:0]  m4;
      logic [7:0]  m8;
      b = req_data_byte;
      lb = hrhp_pkg::to_lower(b);
      keych = (lb >= "a" && lb <= "z") || b == "-" || b == "_";
      st_in = st_ff; idx_in = idx_ff; fs_in = fs_ff; tl_in = tl_ff;
      mm_in = mm_ff; vm_in = vm_ff; km_in = km_ff; cm_in = cm_ff;
      lk_in = lk_ff; bc_in = bc_ff; mr_in = mr_ff; vr_in = vr_ff;
      ka_in = ka_ff; fin_in = fin_ff;
      if (req_restart) begin
         st_in = hrhp_pkg::S_START; idx_in = '0; fs_in = '0; tl_in = '0;
         mm_in = '1; vm_in = '1; km_in = '1; cm_in = 1'b1; lk_in = '0;
         bc_in = 1'b0; mr_in = '0; vr_in = '0; ka_in = 1'b0;
         fin_in = hrhp_pkg::ST_CONTINUE;
      end
      o_wr = 1'b0; o_addr = '0; o_data = '0;
      o_fd = 1'b0; o_id = '0; o_off = '0; o_len = '0;
      verdict = hrhp_pkg::ST_CONTINUE;
      isval = (lk_in >= 4'd1) && (lk_in <= 4'd7);
      got = 1'b0;
      m4 = '0; m8 = '0;
      if (fin_in == hrhp_pkg::ST_CONTINUE) begin
         case (st_in)
            hrhp_pkg::S_START: begin
               if (b != hrhp_pkg::CH_CR && b != hrhp_pkg::CH_LF) begin
                  if (b >= "A" && b <= "Z") begin
                     tl_in = 5'd1;
                     for (int i = 0; i < 4; i++) begin
                        m4[i] = (hrhp_pkg::meth_char(2'(i), 5'd0) == b);
                     end
                     mm_in = m4;
                     st_in = hrhp_pkg::S_METHOD;
                  end else begin
                     verdict = hrhp_pkg::ST_INVALID;
                  end
               end
            end
            hrhp_pkg::S_METHOD: begin
               if (b == " ") begin
                  for (int i = 3; i >= 0; i--) begin
                     if (mm_in[i] && hrhp_pkg::meth_len(2'(i)) == tl_in) begin
                        got = 1'b1; mr_in = 2'(i);
                     end
                  end
                  if (!got) begin
                     verdict = hrhp_pkg::ST_INVALID;
                     mr_in = mr_ff;
                     if (req_restart) mr_in = '0;
                  end else begin
                     st_in = hrhp_pkg::S_URI_BF;
                  end
               end else if (b >= "A" && b <= "Z") begin
                  for (int i = 0; i < 4; i++) begin
                     m4[i] = mm_in[i] && (tl_in < hrhp_pkg::meth_len(2'(i)))
                             && (hrhp_pkg::meth_char(2'(i), tl_in) == b);
                  end
                  mm_in = m4;
                  if (tl_in != 5'd31) tl_in = tl_in + 5'd1;
               end else begin
                  verdict = hrhp_pkg::ST_INVALID;
               end
            end
            hrhp_pkg::S_URI_BF: begin
               if (b != " ") begin
                  if (b != "/" || idx_in >= cap) begin
                     verdict = hrhp_pkg::ST_INVALID;
                  end else begin
                     fs_in = idx_in;
                     o_wr = 1'b1; o_addr = idx_in[9:0]; o_data = b;
                     idx_in = idx_in + 1'b1;
                     st_in = hrhp_pkg::S_URI_IN;
                  end
               end
            end
            hrhp_pkg::S_URI_IN: begin
               if (b == " ") begin
                  o_fd = 1'b1; o_id = 3'd0; o_off = fs_in[9:0];
                  o_len = 11'(idx_in - fs_in);
                  st_in = hrhp_pkg::S_VER_BF;
               end else if (idx_in < cap) begin
                  o_wr = 1'b1; o_addr = idx_in[9:0]; o_data = b;
                  idx_in = idx_in + 1'b1;
               end
            end
            hrhp_pkg::S_VER_BF: begin
               if (b != " ") begin
                  if (b != "H") begin
                     verdict = hrhp_pkg::ST_INVALID;
                  end else begin
                     tl_in = 5'd1; vm_in = 4'b0111;
                     st_in = hrhp_pkg::S_VER_IN;
                  end
               end
            end
            hrhp_pkg::S_VER_IN: begin
               if (b == hrhp_pkg::CH_CR) begin
                  // All three versions are eight characters long.
                  if (tl_in == 5'd8 && vm_in[2:0] != 3'd0) begin
                     vr_in = vm_in[0] ? 2'd0 : (vm_in[1] ? 2'd1 : 2'd2);
                     if (vr_in == 2'd2) ka_in = 1'b1;
                     st_in = hrhp_pkg::S_VER_END;
                  end else begin
                     verdict = hrhp_pkg::ST_INVALID;
                  end
               end else if (b == hrhp_pkg::CH_LF) begin
                  st_in = hrhp_pkg::S_HOST_BF;
               end else begin
                  for (int i = 0; i < 3; i++) begin
                     m4[i] = vm_in[i] && (tl_in < 5'd8)
                             && (hrhp_pkg::ver_char(2'(i), tl_in) == b);
                  end
                  vm_in = m4;
                  if (tl_in != 5'd31) tl_in = tl_in + 5'd1;
               end
            end
            hrhp_pkg::S_VER_END: begin
               if (b == hrhp_pkg::CH_LF) st_in = hrhp_pkg::S_HOST_BF;
            end
            hrhp_pkg::S_HOST_BF: begin
               if (lb != "h") begin
                  verdict = hrhp_pkg::ST_INVALID;
               end else begin
                  tl_in = 5'd1; km_in = 8'd1;
                  st_in = hrhp_pkg::S_HOST_IN;
               end
            end
            hrhp_pkg::S_HOST_IN: begin
               if (b == ":") begin
                  if (tl_in != 5'd4 || !km_in[0]) begin
                     verdict = hrhp_pkg::ST_INVALID;
                  end else begin
                     lk_in = hrhp_pkg::KIND_HOST;
                     st_in = hrhp_pkg::S_VALUE_BF;
                  end
               end else begin
                  if (tl_in >= 5'd4 ||
                      lb != hrhp_pkg::HOST_TXT[31 - 8*tl_in[1:0] -: 8]) begin
                     km_in = 8'd0;
                  end
                  if (tl_in != 5'd31) tl_in = tl_in + 5'd1;
               end
            end
            hrhp_pkg::S_LINE_BF: begin
               if (b == hrhp_pkg::CH_CR) begin
                  bc_in = 1'b1;
               end else if (b == hrhp_pkg::CH_LF && bc_in) begin
                  verdict = hrhp_pkg::ST_FINISHED;
               end else if (keych) begin
                  bc_in = 1'b0; tl_in = 5'd1;
                  for (int i = 0; i < 8; i++) begin
                     m8[i] = (hrhp_pkg::hdr_char(3'(i), 5'd0) == lb);
                  end
                  km_in = m8;
                  st_in = hrhp_pkg::S_KEY_IN;
               end
            end
            hrhp_pkg::S_KEY_IN: begin
               if (b == ":") begin
                  lk_in = hrhp_pkg::KIND_IGNORE;
                  for (int i = 7; i >= 0; i--) begin
                     if (km_in[i] && hrhp_pkg::hdr_len(3'(i)) == tl_in) begin
                        lk_in = hrhp_pkg::hdr_kind(3'(i));
                     end
                  end
                  st_in = hrhp_pkg::S_VALUE_BF;
               end else if (keych) begin
                  for (int i = 0; i < 8; i++) begin
                     m8[i] = km_in[i] && (tl_in < hrhp_pkg::hdr_len(3'(i)))
                             && (hrhp_pkg::hdr_char(3'(i), tl_in) == lb);
                  end
                  km_in = m8;
                  if (tl_in != 5'd31) tl_in = tl_in + 5'd1;
               end else begin
                  verdict = hrhp_pkg::ST_INVALID;
               end
            end
            hrhp_pkg::S_VALUE_BF: begin
               if (b == hrhp_pkg::CH_CR) begin
                  st_in = hrhp_pkg::S_FIELD_END;
               end else if (b == hrhp_pkg::CH_LF) begin
                  st_in = hrhp_pkg::S_LINE_BF;
               end else if (b != " ") begin
                  tl_in = 5'd1;
                  cm_in = (lb == "c");
                  if (isval && idx_in >= cap) begin
                     verdict = hrhp_pkg::ST_INVALID;
                  end else begin
                     if (isval) begin
                        fs_in = idx_in;
                        o_wr = 1'b1; o_addr = idx_in[9:0]; o_data = b;
                        idx_in = idx_in + 1'b1;
                     end
                     st_in = hrhp_pkg::S_VALUE_IN;
                  end
               end
            end
            hrhp_pkg::S_VALUE_IN: begin
               if (b == hrhp_pkg::CH_CR || b == hrhp_pkg::CH_LF) begin
                  if (isval) begin
                     o_fd = 1'b1; o_id = lk_in[2:0]; o_off = fs_in[9:0];
                     o_len = 11'(idx_in - fs_in);
                  end
                  if (lk_in == hrhp_pkg::KIND_CONN && cm_in && tl_in == 5'd5) begin
                     ka_in = 1'b0;
                  end
                  st_in = (b == hrhp_pkg::CH_CR) ? hrhp_pkg::S_FIELD_END
                                                 : hrhp_pkg::S_LINE_BF;
               end else begin
                  if (isval && idx_in < cap) begin
                     o_wr = 1'b1; o_addr = idx_in[9:0]; o_data = b;
                     idx_in = idx_in + 1'b1;
                  end
                  if (tl_in >= 5'd5 || lb != hrhp_pkg::close_char(tl_in)) cm_in = 1'b0;
                  if (tl_in != 5'd31) tl_in = tl_in + 5'd1;
               end
            end
            hrhp_pkg::S_FIELD_END: begin
               if (b == hrhp_pkg::CH_LF) st_in = hrhp_pkg::S_LINE_BF;
            end
            default: begin
               st_in = hrhp_pkg::S_START;
            end
         endcase
         fin_in = verdict;
      end
   end

   // Parse state advances on every accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= hrhp_pkg::S_START; idx_ff <= '0; fs_ff <= '0; tl_ff <= '0;
         mm_ff <= '1; vm_ff <= '1; km_ff <= '1; cm_ff <= 1'b1; lk_ff <= '0;
         bc_ff <= 1'b0; mr_ff <= '0; vr_ff <= '0; ka_ff <= 1'b0;
         fin_ff <= hrhp_pkg::ST_CONTINUE;
      end else if (take) begin
         st_ff <= st_in; idx_ff <= idx_in; fs_ff <= fs_in; tl_ff <= tl_in;
         mm_ff <= mm_in; vm_ff <= vm_in; km_ff <= km_in; cm_ff <= cm_in;
         lk_ff <= lk_in; bc_ff <= bc_in; mr_ff <= mr_in; vr_ff <= vr_in;
         ka_ff <= ka_in; fin_ff <= fin_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (take) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_status       <= fin_in;
         rsp_store_write  <= o_wr;
         rsp_store_addr   <= o_addr;
         rsp_store_data   <= o_data;
         rsp_field_done   <= o_fd;
         rsp_field_id     <= o_id;
         rsp_field_offset <= o_off;
         rsp_field_length <= o_len;
         rsp_method       <= mr_in;
         rsp_version      <= vr_in;
         rsp_keep_alive   <= ka_in;
      end
   end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTTP request header parser testbench
// Streams directed and random request bytes through the parser, predicts
// every result from a behavioural copy of the parse machine and compares it
// field by field while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [1:0]  status;
   logic        store_write;
   logic [9:0]  store_addr;
   logic [7:0]  store_data;
   logic        field_done;
   logic [2:0]  field_id;
   logic [9:0]  field_offset;
   logic [10:0] field_length;
   logic [1:0]  method;
   logic [1:0]  version;
   logic        keep_alive;
} parse_result_type;

// Behavioural parse machine plus the queue of results it still awaits.
class header_scoreboard;
   parse_result_type awaited_q[$];
   int            mismatches;
   logic [10:0]   capacity;
   logic [3:0]    state;
   logic [10:0]   wr_index, fld_start;
   logic [4:0]    tok_len;
   logic [3:0]    meth_set, ver_set, kind;
   logic [7:0]    key_set;
   logic          close_ok, blank_seen, alive;
   logic [1:0]    meth, ver, verdict;
   string         meth_names[4];
   string         ver_names[3];
   string         key_names[8];
   logic [3:0]    key_kinds[8];

   function new();
      meth_names = '{"GET", "PUT", "POST", "HEAD"};
      ver_names  = '{"HTTP/0.9", "HTTP/1.0", "HTTP/1.1"};
      key_names  = '{"connection", "referer", "user-agent", "accept",
                     "accept-encoding", "accept-language", "range", "cookie"};
      key_kinds  = '{hrhp_pkg::KIND_CONN, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
                     hrhp_pkg::KIND_RANGE, 4'd7};
      mismatches = 0;
      capacity   = 11'd1024;
      clear();
   endfunction

   function void clear();
      state = hrhp_pkg::S_START; wr_index = 0; fld_start = 0; tok_len = 0;
      meth_set = 4'hF; ver_set = 4'hF; key_set = 8'hFF; close_ok = 1;
      kind = hrhp_pkg::KIND_IGNORE; blank_seen = 0; meth = 0; ver = 0; alive = 0;
      verdict = hrhp_pkg::ST_CONTINUE;
   endfunction

   function logic [7:0] lower(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function bit key_char(logic [7:0] c);
      logic [7:0] l;
      l = lower(c);
      return (l >= "a" && l <= "z") || c == "-" || c == "_";
   endfunction

   function bit char_at(string s, int pos, logic [7:0] c);
      return pos < s.len() && s[pos] == c;
   endfunction

   function void grow();
      if (tok_len < 5'd31) tok_len++;
   endfunction

   function void store_byte(logic [7:0] b, logic [10:0] cap, ref parse_result_type r);
      if (wr_index < cap) begin
         r.store_write = 1; r.store_addr = wr_index[9:0]; r.store_data = b;
         wr_index++;
      end
   endfunction

   function bit begin_field(logic [7:0] b, logic [10:0] cap, ref parse_result_type r);
      if (wr_index >= cap) return 0;
      fld_start = wr_index;
      store_byte(b, cap, r);
      return 1;
   endfunction

   function void end_field(logic [3:0] id, ref parse_result_type r);
      r.field_done = 1; r.field_id = id[2:0]; r.field_offset = fld_start[9:0];
      r.field_length = wr_index - fld_start;
   endfunction

   // Works out the result of one accepted byte and queues it.
   function void note_byte(logic [7:0] b, logic restart);
      parse_result_type r;
      logic [7:0]    lb;
      logic [10:0]   cap;
      logic [1:0]    v;
      bit            capt;
      int            hit;
      lb  = lower(b);
      cap = (capacity < 11'd1024) ? capacity : 11'd1024;
      v   = hrhp_pkg::ST_CONTINUE;
      hit = -1;
      r   = '0;
      if (restart) clear();
      capt = kind >= 4'd1 && kind <= 4'd7;
      if (verdict == hrhp_pkg::ST_CONTINUE) begin
         case (state)
            hrhp_pkg::S_START: begin
               if (b == hrhp_pkg::CH_CR || b == hrhp_pkg::CH_LF) begin
               end else if (b >= "A" && b <= "Z") begin
                  tok_len = 1;
                  for (int i = 0; i < 4; i++) meth_set[i] = char_at(meth_names[i], 0, b);
                  state = hrhp_pkg::S_METHOD;
               end else v = hrhp_pkg::ST_INVALID;
            end
            hrhp_pkg::S_METHOD: begin
               if (b == " ") begin
                  for (int i = 3; i >= 0; i--)
                     if (meth_set[i] && meth_names[i].len() == tok_len) hit = i;
                  if (hit < 0) v = hrhp_pkg::ST_INVALID;
                  else begin meth = 2'(hit); state = hrhp_pkg::S_URI_BF; end
               end else if (b >= "A" && b <= "Z") begin
                  for (int i = 0; i < 4; i++)
                     if (!char_at(meth_names[i], tok_len, b)) meth_set[i] = 0;
                  grow();
               end else v = hrhp_pkg::ST_INVALID;
            end
            hrhp_pkg::S_URI_BF: begin
               if (b != " ") begin
                  if (b != "/" || !begin_field(b, cap, r)) v = hrhp_pkg::ST_INVALID;
                  else state = hrhp_pkg::S_URI_IN;
               end
            end
            hrhp_pkg::S_URI_IN: begin
               if (b == " ") begin end_field(0, r); state = hrhp_pkg::S_VER_BF; end
               else store_byte(b, cap, r);
            end
            hrhp_pkg::S_VER_BF: begin
               if (b != " ") begin
                  if (b != "H") v = hrhp_pkg::ST_INVALID;
                  else begin tok_len = 1; ver_set = 4'h7; state = hrhp_pkg::S_VER_IN; end
               end
            end
            hrhp_pkg::S_VER_IN: begin
               if (b == hrhp_pkg::CH_CR) begin
                  for (int i = 2; i >= 0; i--)
                     if (ver_set[i] && ver_names[i].len() == tok_len) hit = i;
                  if (hit < 0) v = hrhp_pkg::ST_INVALID;
                  else begin
                     ver = 2'(hit);
                     if (hit == 2) alive = 1;
                     state = hrhp_pkg::S_VER_END;
                  end
               end else if (b == hrhp_pkg::CH_LF) state = hrhp_pkg::S_HOST_BF;
               else begin
                  for (int i = 0; i < 3; i++)
                     if (!char_at(ver_names[i], tok_len, b)) ver_set[i] = 0;
                  grow();
               end
            end
            hrhp_pkg::S_VER_END: if (b == hrhp_pkg::CH_LF) state = hrhp_pkg::S_HOST_BF;
            hrhp_pkg::S_HOST_BF: begin
               if (lb != "h") v = hrhp_pkg::ST_INVALID;
               else begin tok_len = 1; key_set = 1; state = hrhp_pkg::S_HOST_IN; end
            end
            hrhp_pkg::S_HOST_IN: begin
               if (b == ":") begin
                  if (tok_len != 4 || !key_set[0]) v = hrhp_pkg::ST_INVALID;
                  else begin kind = hrhp_pkg::KIND_HOST; state = hrhp_pkg::S_VALUE_BF; end
               end else begin
                  if (!char_at("host", tok_len, lb)) key_set = 0;
                  grow();
               end
            end
            hrhp_pkg::S_LINE_BF: begin
               if (b == hrhp_pkg::CH_CR) blank_seen = 1;
               else if (b == hrhp_pkg::CH_LF && blank_seen) v = hrhp_pkg::ST_FINISHED;
               else if (key_char(b)) begin
                  blank_seen = 0; tok_len = 1;
                  for (int i = 0; i < 8; i++) key_set[i] = char_at(key_names[i], 0, lb);
                  state = hrhp_pkg::S_KEY_IN;
               end
            end
            hrhp_pkg::S_KEY_IN: begin
               if (b == ":") begin
                  for (int i = 7; i >= 0; i--)
                     if (key_set[i] && key_names[i].len() == tok_len) hit = i;
                  kind = (hit < 0) ? hrhp_pkg::KIND_IGNORE : key_kinds[hit];
                  state = hrhp_pkg::S_VALUE_BF;
               end else if (key_char(b)) begin
                  for (int i = 0; i < 8; i++)
                     if (!char_at(key_names[i], tok_len, lb)) key_set[i] = 0;
                  grow();
               end else v = hrhp_pkg::ST_INVALID;
            end
            hrhp_pkg::S_VALUE_BF: begin
               if (b == " ") begin
               end else if (b == hrhp_pkg::CH_CR) state = hrhp_pkg::S_FIELD_END;
               else if (b == hrhp_pkg::CH_LF) state = hrhp_pkg::S_LINE_BF;
               else begin
                  tok_len = 1;
                  close_ok = (lb == "c");
                  if (capt && !begin_field(b, cap, r)) v = hrhp_pkg::ST_INVALID;
                  else state = hrhp_pkg::S_VALUE_IN;
               end
            end
            hrhp_pkg::S_VALUE_IN: begin
               if (b == hrhp_pkg::CH_CR || b == hrhp_pkg::CH_LF) begin
                  if (capt) end_field(kind, r);
                  if (kind == hrhp_pkg::KIND_CONN && close_ok && tok_len == 5) alive = 0;
                  state = (b == hrhp_pkg::CH_CR) ? hrhp_pkg::S_FIELD_END
                                                 : hrhp_pkg::S_LINE_BF;
               end else begin
                  if (capt) store_byte(b, cap, r);
                  if (!char_at("close", tok_len, lb)) close_ok = 0;
                  grow();
               end
            end
            hrhp_pkg::S_FIELD_END: if (b == hrhp_pkg::CH_LF) state = hrhp_pkg::S_LINE_BF;
            default: state = hrhp_pkg::S_START;
         endcase
         verdict = v;
      end
      r.status = verdict; r.method = meth; r.version = ver; r.keep_alive = alive;
      awaited_q.push_back(r);
   endfunction

   function void check_result(parse_result_type got);
      parse_result_type exp;
      if (awaited_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("tb: unexpected result %p", got);
         return;
      end
      exp = awaited_q.pop_front();
      if (got !== exp) begin
         mismatches++;
         if (mismatches <= 10) $display("tb: mismatch\n  expected %p\n  actual   %p", exp, got);
      end
   endfunction
endclass

module testbench;

   localparam int IDLE_LIMIT = 4000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write = 0;
   logic [10:0] csr_data = 0;
   logic        req_valid = 0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 0;
   logic        req_restart = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   parse_result_type rsp;

   header_scoreboard parse_board = new();
   logic [7:0] byte_stream[$];
   int         bytes_sent = 0;
   int         idle_cycles = 0;
   bit         no_gaps = 0;

   always #4 clock = ~clock;

   http_request_header_parser dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_data(csr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_restart(req_restart),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp.status), .rsp_store_write(rsp.store_write),
      .rsp_store_addr(rsp.store_addr), .rsp_store_data(rsp.store_data),
      .rsp_field_done(rsp.field_done), .rsp_field_id(rsp.field_id),
      .rsp_field_offset(rsp.field_offset), .rsp_field_length(rsp.field_length),
      .rsp_method(rsp.method), .rsp_version(rsp.version),
      .rsp_keep_alive(rsp.keep_alive)
   );

   // Gap lengths: mostly none or short, now and then a long one. While no_gaps
   // is set both sides run flat out.
   function automatic int pick_gap();
      if (no_gaps || $urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Every result transfer is handed to the scoreboard in the same edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) parse_board.check_result(rsp);
   end

   // Watchdog on cycles without any transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Receiver. Early in the run it holds off for a long stretch so that the
   // parser fills up and has to stall the sender.
   initial begin
      int gap;
      int rounds;
      rounds = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         rounds++;
         if (rounds == 60) begin
            rsp_ready <= 0;
            repeat (300) @(posedge clock);
         end
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   // One byte transfer. Valid is only lowered when a gap is actually taken,
   // so back-to-back bytes keep it high across the edge.
   task automatic send_byte(input logic [7:0] b, input logic restart);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1;
      req_data_byte <= b;
      req_restart   <= restart;
      do @(posedge clock); while (!(req_valid && req_ready));
      parse_board.note_byte(b, restart);
      bytes_sent++;
   endtask

   // Sends the assembled request; its first byte starts a new parse.
   task automatic flush_stream();
      bit first;
      first = 1;
      foreach (byte_stream[i]) begin
         send_byte(byte_stream[i], first || $urandom_range(0, 299) == 0);
         first = 0;
      end
      byte_stream.delete();
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (parse_board.awaited_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Capacity changes only once the parser has gone quiet.
   task automatic set_capacity(input logic [10:0] cap);
      wait_drained();
      csr_write <= 1;
      csr_data  <= cap;
      @(posedge clock);
      csr_write <= 0;
      parse_board.capacity = cap;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) byte_stream.push_back(s[i]);
   endtask

   task automatic add_crlf();
      byte_stream.push_back(hrhp_pkg::CH_CR);
      byte_stream.push_back(hrhp_pkg::CH_LF);
   endtask

   // Line endings after a value: CR LF, bare LF, or CR with junk before LF.
   task automatic add_line_end();
      case ($urandom_range(0, 5))
         0: byte_stream.push_back(hrhp_pkg::CH_LF);
         1: begin
            byte_stream.push_back(hrhp_pkg::CH_CR);
            add_text("zz");
            byte_stream.push_back(hrhp_pkg::CH_LF);
         end
         default: add_crlf();
      endcase
   endtask

   task automatic add_printable(input int n);
      repeat (n) byte_stream.push_back(8'($urandom_range(33, 126)));
   endtask

   function automatic string mix_case(input string s);
      string t;
      t = s;
      for (int i = 0; i < t.len(); i++) begin
         if ($urandom_range(0, 1) && t[i] >= "a" && t[i] <= "z") t[i] = t[i] - 8'd32;
         else if ($urandom_range(0, 1) && t[i] >= "A" && t[i] <= "Z") t[i] = t[i] + 8'd32;
      end
      return t;
   endfunction

   // A mostly well-formed request with random content. Some are corrupted
   // at one byte or cut short so that the invalid paths are reached too.
   task automatic build_request();
      string methods[6];
      string versions[5];
      string keys[11];
      int    k;
      methods  = '{"GET", "PUT", "POST", "HEAD", "GETX", "DELETE"};
      versions = '{"HTTP/0.9", "HTTP/1.0", "HTTP/1.1", "HTTP/1.1", "HTTP/2.0"};
      keys     = '{"Connection", "Referer", "User-Agent", "Accept", "Accept-Encoding",
                   "Accept-Language", "Range", "Cookie", "X-Trace_Id", "Hostname", "Accep"};
      repeat ($urandom_range(0, 2))
         byte_stream.push_back($urandom_range(0, 1) ? hrhp_pkg::CH_CR : hrhp_pkg::CH_LF);
      add_text($urandom_range(0, 9) ? methods[$urandom_range(0, 3)] : methods[$urandom_range(4, 5)]);
      add_text($urandom_range(0, 3) ? " " : "  ");
      byte_stream.push_back("/");
      add_printable($urandom_range(0, 19) ? $urandom_range(0, 10) : $urandom_range(30, 60));
      add_text(" ");
      add_text(versions[$urandom_range(0, 4)]);
      if ($urandom_range(0, 7)) add_crlf(); else byte_stream.push_back(hrhp_pkg::CH_LF);
      add_text(mix_case($urandom_range(0, 15) ? "Host" : "Hosts"));
      add_text(":");
      if ($urandom_range(0, 5)) add_text(" ");
      if ($urandom_range(0, 7)) add_printable($urandom_range(1, 8));
      add_line_end();
      repeat ($urandom_range(0, 4)) begin
         k = $urandom_range(0, 10);
         add_text(mix_case(keys[k]));
         add_text(":");
         if ($urandom_range(0, 2)) add_text(" ");
         if (k == 0 && $urandom_range(0, 2)) begin
            add_text(mix_case($urandom_range(0, 3) ? "close" : "closed"));
         end else if ($urandom_range(0, 7)) begin
            add_printable($urandom_range(1, 10));
         end
         add_line_end();
      end
      add_crlf();
      // corrupt one byte of about one request in six
      if ($urandom_range(0, 5) == 0)
         byte_stream[$urandom_range(0, byte_stream.size() - 1)] = 8'($urandom_range(0, 255));
      // cut about one in ten short
      if ($urandom_range(0, 9) == 0)
         byte_stream = byte_stream[0:$urandom_range(0, byte_stream.size() - 1)];
   endtask

   initial begin
      logic [10:0] caps[7];
      caps = '{11'd1024, 11'd0, 11'd1, 11'd6, 11'd20, 11'd2047, 11'd1023};
      repeat (12) @(posedge clock);
      reset <= 0;

      // Directed: a complete HTTP/1.1 request with a close, then the extremes
      // of the byte field and a sticky status.
      no_gaps = 1;
      add_text("GET /a HTTP/1.1"); add_crlf();
      add_text("hOST: h"); add_crlf();
      add_text("Connection: close"); add_crlf(); add_crlf();
      flush_stream();
      send_byte(8'h00, 1);
      send_byte(8'hFF, 0);
      no_gaps = 0;
      // empty URI store: the URI finds the store full
      set_capacity(11'd0);
      add_text("PUT / HTTP/1.0"); add_crlf();
      flush_stream();
      // tiny store: the URI is truncated, the cookie value finds it full
      set_capacity(11'd3);
      add_text("HEAD /xyz HTTP/0.9"); byte_stream.push_back(hrhp_pkg::CH_LF);
      add_text("Host:"); add_crlf();
      add_text("Cookie: q"); byte_stream.push_back(hrhp_pkg::CH_LF);
      flush_stream();

      // Random part, moving through several capacities including both ends.
      for (int phase = 0; bytes_sent < 400; phase++) begin
         if (phase % 12 == 0)
            set_capacity($urandom_range(0, 3) ? caps[(phase / 12) % 7]
                                              : 11'($urandom_range(0, 2047)));
         no_gaps = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) byte_stream.push_back(8'($urandom_range(0, 255)));
         end else begin
            build_request();
         end
         flush_stream();
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (parse_board.mismatches == 0 && parse_board.awaited_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
